[src/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int COUNT_W        = 5;
  localparam int REQ_W          = 3;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_PEEK       = 3'd4;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_req;   // latch the incoming beat
    logic exec;       // update pointers, write push word, read popped slot
    logic rd_front;   // read front slot, capture popped word
    logic rd_back;    // read back slot, capture front word
    logic load_out;   // load the result register
  } deq_cmd_t;

endpackage

`default_nettype wire

[src/deq_ctrl.sv]
// Request sequencer for the double-ended queue.
// Depends on deq_pkg; drives deq_dpath through deq_cmd_t.
`default_nettype none

module deq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output deq_pkg::deq_cmd_t    cmd
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_FRONT,
    S_RD_BACK,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load_req = in_valid && (state == S_IDLE);
    cmd.exec     = (state == S_EXEC);
    cmd.rd_front = (state == S_RD_FRONT);
    cmd.rd_back  = (state == S_RD_BACK);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result beat may replace the one leaving on this edge
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_EXEC;
        S_EXEC:     state <= S_RD_FRONT;
        S_RD_FRONT: state <= S_RD_BACK;
        S_RD_BACK:  state <= S_DONE;
        S_DONE:     if (out_free) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/deq_dpath.sv]
// Datapath of the double-ended queue: slot memory, ring pointers, fill count
// and the result register. Depends on deq_pkg; commanded by deq_ctrl.
`default_nettype none

module deq_dpath #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire deq_pkg::deq_cmd_t                   cmd,
  input  wire logic        [deq_pkg::REQ_W-1:0]    req_type,
  input  wire logic signed [deq_pkg::FIELD_W-1:0]  push_value,
  output logic signed      [deq_pkg::FIELD_W-1:0]  popped_value,
  output logic                                     ok,
  output logic signed      [deq_pkg::FIELD_W-1:0]  front_value,
  output logic signed      [deq_pkg::FIELD_W-1:0]  back_value,
  output logic                                     is_empty,
  output logic             [deq_pkg::COUNT_W-1:0]  count
);
  import deq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [PW-1:0]         ptr_t;

  word_t         mem [DEPTH];
  word_t         rd_data;
  ptr_t          head;
  ptr_t          tail;
  logic [CW-1:0] cnt;

  req_t  req_q;
  word_t word_q;
  logic  ok_q;
  logic  pop_ok_q;
  word_t popped_q;
  word_t front_q;

  logic  is_push, is_pop, full, empty;
  logic  we, re;
  ptr_t  wa, ra;
  ptr_t  head_dec, head_inc, tail_dec, tail_inc;
  logic [63:0] push_wide;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // Words leave zero-extended or truncated to the field width
  function automatic logic [FIELD_W-1:0] to_field(input word_t w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[FIELD_W-1:0];
  endfunction

  assign head_dec = ptr_dec(head);
  assign head_inc = ptr_inc(head);
  assign tail_dec = ptr_dec(tail);
  assign tail_inc = ptr_inc(tail);

  assign push_wide = 64'(unsigned'(push_value));

  assign is_push = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
  assign is_pop  = (req_q == REQ_POP_FRONT)  || (req_q == REQ_POP_BACK);
  assign full    = (cnt == CNT_FULL);
  assign empty   = (cnt == '0);

  always_comb begin
    we = cmd.exec && is_push && !full;
    wa = (req_q == REQ_PUSH_FRONT) ? head_dec : tail;
    re = 1'b0;
    ra = head;
    if (cmd.exec) begin
      re = is_pop && !empty;
      ra = (req_q == REQ_POP_FRONT) ? head : tail_dec;
    end else if (cmd.rd_front) begin
      re = 1'b1;
      ra = head;
    end else if (cmd.rd_back) begin
      re = 1'b1;
      ra = tail_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= word_q;
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else if (cmd.exec) begin
      case (req_q)
        REQ_PUSH_FRONT: if (!full) begin
          head <= head_dec;
          cnt  <= cnt + 1'b1;
        end
        REQ_PUSH_BACK: if (!full) begin
          tail <= tail_inc;
          cnt  <= cnt + 1'b1;
        end
        REQ_POP_FRONT: if (!empty) begin
          head <= head_inc;
          cnt  <= cnt - 1'b1;
        end
        REQ_POP_BACK: if (!empty) begin
          tail <= tail_dec;
          cnt  <= cnt - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q  <= req_type;
      word_q <= push_wide[DATA_WIDTH-1:0];
    end
    if (cmd.exec) begin
      ok_q     <= !(is_push && full) && !(is_pop && empty);
      pop_ok_q <= is_pop && !empty;
    end
    if (cmd.rd_front) popped_q <= rd_data;
    if (cmd.rd_back)  front_q  <= rd_data;
    if (cmd.load_out) begin
      popped_value <= to_field(pop_ok_q ? popped_q : ALL_ONES);
      front_value  <= to_field(empty ? ALL_ONES : front_q);
      back_value   <= to_field(empty ? ALL_ONES : rd_data);
      ok           <= ok_q;
      is_empty     <= empty;
      count        <= COUNT_W'(64'(cnt));
    end
  end

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
// Top level of the double-ended queue: ring buffer of signed words.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------------------------
//  request | in_valid  | in_ready  | req_type, push_value
//  result  | out_valid | out_ready | popped_value, ok, front_value, back_value,
//          |           |           | is_empty, count
//
// After its request is accepted, the result beat passes four steps: update
// with pop read, front read, back read, result load; the single read port of
// the slot memory sets this. The next request is taken only in the idle state
// that follows the result load. The result register lets the next request be
// accepted while a result waits; that request holds in its last step until
// the result is taken.
// Reset clears sequencer state, out_valid, pointers and count; slot contents are not reset.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [deq_pkg::REQ_W-1:0]    req_type,
  input  wire logic signed [deq_pkg::FIELD_W-1:0]  push_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [deq_pkg::FIELD_W-1:0]  popped_value,
  output logic                                     ok,
  output logic signed      [deq_pkg::FIELD_W-1:0]  front_value,
  output logic signed      [deq_pkg::FIELD_W-1:0]  back_value,
  output logic                                     is_empty,
  output logic             [deq_pkg::COUNT_W-1:0]  count
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  deq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .push_value   (push_value),
    .popped_value (popped_value),
    .ok           (ok),
    .front_value  (front_value),
    .back_value   (back_value),
    .is_empty     (is_empty),
    .count        (count)
  );

endmodule

`default_nettype wire

[src/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on deq_pkg and double_ended_queue.
`default_nettype none

module deq_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic        [deq_pkg::REQ_W-1:0]    req_type,
  input wire logic signed [deq_pkg::FIELD_W-1:0]  push_value,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [deq_pkg::FIELD_W-1:0]  popped_value,
  input wire logic                                ok,
  input wire logic signed [deq_pkg::FIELD_W-1:0]  front_value,
  input wire logic signed [deq_pkg::FIELD_W-1:0]  back_value,
  input wire logic                                is_empty,
  input wire logic        [deq_pkg::COUNT_W-1:0]  count
);
  import deq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(ok)
      && $stable(front_value) && $stable(back_value) && $stable(count))
    else $error("result beat changed while stalled");

  // a waiting request beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(push_value))
    else $error("request beat changed while waiting");

  // one request in flight: no accept on the cycle after an accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == (count == '0))
    else $error("empty flag disagrees with count");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> front_value == back_value)
    else $error("front and back differ on an empty queue");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

[sim/double_ended_queue_tb.sv]
// Self-checking bench for double_ended_queue: directed corner requests, then
// random request streams that swing the ring between empty and full.
// Depends on deq_pkg and the double_ended_queue RTL; needs nothing else.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam req_t REQ_SPARE_FIRST = 3'd5;
  localparam req_t REQ_SPARE_LAST  = 3'd7;
  localparam logic [FIELD_W-1:0] NO_WORD = '1;  // -1: no word to report
  localparam int NUM_RANDOM  = 1900;
  localparam int LONG_HOLD   = 150;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic               pause;  // wait for every result before going on
    req_t               kind;
    logic [FIELD_W-1:0] word;
  } beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] popped;
    logic               ok;
    logic [FIELD_W-1:0] front;
    logic [FIELD_W-1:0] back;
    logic               empty;
    logic [COUNT_W-1:0] fill;
  } answer_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_style_t;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  req_t                      req_type   = REQ_PEEK;
  logic signed [FIELD_W-1:0] push_value = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic signed [FIELD_W-1:0] popped_value;
  logic                      ok;
  logic signed [FIELD_W-1:0] front_value;
  logic signed [FIELD_W-1:0] back_value;
  logic                      is_empty;
  logic        [COUNT_W-1:0] count;

  double_ended_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .popped_value(popped_value),
    .ok          (ok),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .count       (count)
  );

  always #10 clk = ~clk;

  beat_t   request_backlog[$];
  answer_t awaited_answers[$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      outstanding  = 0;
  int      quiet_cycles = 0;

  // Shadow copy of the ring
  logic [FIELD_W-1:0] ring [DEPTH_DEF];
  int head_slot = 0;
  int tail_slot = 0;
  int held      = 0;

  function automatic answer_t serve_request(req_t kind, logic [FIELD_W-1:0] word);
    answer_t a;
    a = '{popped: NO_WORD, ok: 1'b1, front: NO_WORD, back: NO_WORD,
          empty: 1'b0, fill: '0};
    case (kind) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held == DEPTH_DEF) begin
          a.ok = 1'b0;
        end else if (kind == REQ_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH_DEF - 1) % DEPTH_DEF;
          ring[head_slot] = word;
          held++;
        end else begin
          ring[tail_slot] = word;
          tail_slot = (tail_slot + 1) % DEPTH_DEF;
          held++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (held == 0) begin
          a.ok = 1'b0;
        end else if (kind == REQ_POP_FRONT) begin
          a.popped = ring[head_slot];
          head_slot = (head_slot + 1) % DEPTH_DEF;
          held--;
        end else begin
          tail_slot = (tail_slot + DEPTH_DEF - 1) % DEPTH_DEF;
          a.popped = ring[tail_slot];
          held--;
        end
      end
      default: ;  // peek and spare codes leave the ring alone
    endcase
    if (held != 0) begin
      a.front = ring[head_slot];
      a.back  = ring[(tail_slot + DEPTH_DEF - 1) % DEPTH_DEF];
    end
    a.empty = (held == 0);
    a.fill  = COUNT_W'(held);
    return a;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [FIELD_W-1:0] got,
                               logic [FIELD_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %h want %h",
                              results_seen, name, got, want));
  endtask

  function automatic logic [FIELD_W-1:0] random_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_beat(logic pause, req_t kind, logic [FIELD_W-1:0] word);
    beat_t b;
    b.pause = pause;
    b.kind  = kind;
    b.word  = word;
    request_backlog.insert(request_backlog.size(), b);
  endfunction

  // Driver: bursts of beats with random gaps, occasionally a long unbroken run
  always @(posedge clk) begin : driver
    beat_t next;
    int    burst_left;
    int    gap_left;
    if (rst) begin
      in_valid   <= 1'b0;
      outstanding = 0;
      burst_left  = $urandom_range(1, 12);
      gap_left    = 0;
    end else begin
      outstanding += int'(in_valid && in_ready) - int'(out_valid && out_ready);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0 && request_backlog[0].pause) begin
          in_valid <= 1'b0;
          if (outstanding == 0)
            request_backlog.delete(0);
        end else if (request_backlog.size() != 0) begin
          next = request_backlog[0];
          request_backlog.delete(0);
          in_valid   <= 1'b1;
          req_type   <= next.kind;
          push_value <= next.word;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style is redrawn at the end of each random run; two long holds
  always @(posedge clk) begin : receiver
    int        taken;
    int        hold_left;
    int        style_left;
    int        pattern_step;
    rx_style_t style;
    if (rst) begin
      out_ready   <= 1'b0;
      taken        = 0;
      hold_left    = 0;
      style_left   = 0;
      pattern_step = 0;
      style        = RX_OPEN;
    end else begin
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 300 || taken == 1200)
          hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(10, 80);
      end else begin
        style_left--;
      end
      pattern_step++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (style)
          RX_OPEN:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:  out_ready <= ((pattern_step % 5) < 2);
        endcase
      end
    end
  end

  // Prediction on each accepted request beat, checking on each result beat
  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        awaited_answers.insert(awaited_answers.size(),
                               serve_request(req_type, push_value));
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_answers.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing outstanding", results_seen));
        end else begin
          want = awaited_answers[0];
          awaited_answers.delete(0);
          compare_field("popped_value", popped_value, want.popped);
          compare_field("ok", FIELD_W'(ok), FIELD_W'(want.ok));
          compare_field("front_value", front_value, want.front);
          compare_field("back_value", back_value, want.back);
          compare_field("is_empty", FIELD_W'(is_empty), FIELD_W'(want.empty));
          compare_field("count", FIELD_W'(count), FIELD_W'(want.fill));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] corner_words [8];
    int   seg_left;
    int   push_pct;
    int   roll;
    req_t kind;
    corner_words = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000,
                     32'h0000_0001, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555};
    seg_left = 0;
    push_pct = 50;

    // empty ring: both pops fail, peek and spare codes report empty
    add_beat(1'b0, REQ_POP_FRONT, random_word());
    add_beat(1'b0, REQ_POP_BACK, random_word());
    add_beat(1'b0, REQ_PEEK, random_word());
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
      add_beat(1'b0, req_t'(c), random_word());
    // fill to the brim from both ends, then overflow at each end and pop once at each end
    for (int n = 0; n < DEPTH_DEF; n++)
      add_beat(1'b0, n[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
               (n < 8) ? corner_words[n] : random_word());
    add_beat(1'b0, REQ_PUSH_FRONT, random_word());
    add_beat(1'b0, REQ_PUSH_BACK, random_word());
    add_beat(1'b0, REQ_POP_FRONT, random_word());
    add_beat(1'b0, REQ_POP_BACK, random_word());
    add_beat(1'b1, REQ_PEEK, '0);

    // random part: segments biased towards draining, balance or filling
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        push_pct = 25 * $urandom_range(1, 3);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        kind = req_t'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      else if (roll < 8)
        kind = REQ_PEEK;
      else if ($urandom_range(0, 99) < push_pct)
        kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      else
        kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
      add_beat(1'b0, kind, random_word());
      if (n == NUM_RANDOM / 2)
        add_beat(1'b1, REQ_PEEK, '0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || in_valid || outstanding != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_answers.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
